### rtl/smam_pkg.sv
// Shared types and constants for the sparse matrix add/multiply block.
package smam_pkg;

  localparam int POS_BITS = 3;
  localparam int RES_BITS = 40;
  localparam int OP_BITS  = 3;
  localparam int DIM_BITS = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int VALUE_BITS = 16;

  localparam logic [OP_BITS-1:0] OP_LOAD_A = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_B = 3'd1;
  localparam logic [OP_BITS-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_COLS = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]           operation;
    logic [POS_BITS-1:0]          row;
    logic [POS_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [POS_BITS-1:0]        res_row;
    logic [POS_BITS-1:0]        res_col;
    logic signed [RES_BITS-1:0] res_value;
    logic                       is_empty;
    logic                       last;
  } out_word_t;

endpackage

### rtl/smam_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module smam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/sparse_matrix_add_multiply.sv
// Top level of the sparse matrix add/multiply block: control sequencer around three RAMs.
//
// Loads (A entry, B entry), clear of the A list and undefined codes are accepted
// directly in the idle state. A clear empties the A list at once (its count drops to
// zero) and then sweeps B, one entry a cycle, all MAX_DIM*MAX_DIM entries, during which
// no word is accepted; the same sweep runs after reset. Add and multiply run from the
// three RAMs with registered reads, so most steps have a read state and a use state:
// an init pass writes the result region of the accumulator (B values for add, zero for
// multiply), then each A entry is fetched and checked and, if inside the configured A
// dimensions, folded in with a read-modify-write (add: one; multiply: one per result
// column, b_cols of them), a final index check ends the list walk, then a scan reads
// every result entry and emits the nonzero ones in row-major order. The latest nonzero
// word is held back in a staging register so the final one can carry last; a closing
// state sends it, or one empty word. The scan holds while a finished word waits in the
// output register.
module sparse_matrix_add_multiply
  import smam_pkg::*;
#(
  parameter int MAX_DIM     = 8,
  parameter int MAX_NONZERO = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_word_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_word_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int CA     = $clog2(CELLS);
  localparam int LA     = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int CNT_W  = $clog2(MAX_NONZERO + 1);
  localparam int AW     = 2 * POS_BITS + VALUE_BITS;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_INIT, S_INIT_W, S_AREAD, S_AWAIT, S_RMW_R, S_RMW_W,
    S_SCAN, S_SCAN_W, S_DONE
  } state_t;

  state_t state;
  logic mul;
  logic [DIM_BITS-1:0] a_rows, a_cols, b_cols;
  logic [CNT_W-1:0] a_count, a_idx;
  logic [CA-1:0] sweep;
  logic [POS_BITS-1:0] r, c, j;
  logic [POS_BITS-1:0] er, ec;
  logic signed [VALUE_BITS-1:0] ev;
  logic signed [RES_BITS-1:0] prod;
  logic pend_valid;
  out_word_t pend;
  logic stg_valid;      // a nonzero word is held back, waiting to learn if it is last
  out_word_t stg;
  logic pend_load;

  // clamped dimensions
  function automatic logic [DIM_BITS-1:0] clamp(input logic [DIM_BITS-1:0] v);
    if (v == '0) return DIM_BITS'(1);
    if (32'(v) > MAX_DIM) return DIM_BITS'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [CA-1:0] cell_addr(input logic [POS_BITS-1:0] rr,
                                              input logic [POS_BITS-1:0] cc);
    return CA'(32'(rr) * MAX_DIM + 32'(cc));
  endfunction

  logic [DIM_BITS-1:0] nrows, ncols;
  assign nrows = a_rows;
  assign ncols = mul ? b_cols : a_cols;

  // RAM ports
  logic a_we; logic [LA-1:0] a_wa, a_ra; logic [AW-1:0] a_wd, a_rd;
  logic b_we; logic [CA-1:0] b_wa, b_ra; logic [VALUE_BITS-1:0] b_wd, b_rd;
  logic c_we; logic [CA-1:0] c_wa, c_ra; logic [RES_BITS-1:0] c_wd, c_rd;

  smam_ram #(.WIDTH(AW), .DEPTH(MAX_NONZERO > 1 ? MAX_NONZERO : 2)) u_alist (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  smam_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_bstore (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  smam_ram #(.WIDTH(RES_BITS), .DEPTH(CELLS)) u_acc (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  logic signed [VALUE_BITS-1:0] in_val;
  assign in_val = VALUE_BITS'(in_data.value);

  // B entries are signed
  logic signed [VALUE_BITS-1:0] b_sv;
  assign b_sv = b_rd;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = pend_valid;
  assign out_data  = pend;

  logic accept;
  assign accept = in_valid && in_ready;

  logic [POS_BITS-1:0] a_row_rd, a_col_rd;
  logic signed [VALUE_BITS-1:0] a_val_rd;
  assign {a_row_rd, a_col_rd, a_val_rd} = a_rd;

  logic last_cell;
  assign last_cell = (4'(c) == ncols - 4'd1) && (4'(r) == nrows - 4'd1);

  // output register loads a word: a held word pushed out by a newer one, or the closing word
  assign pend_load = (state == S_SCAN_W && c_rd != '0 && stg_valid) ||
                     (state == S_DONE && (!pend_valid || out_ready));

  // combinational RAM control
  always_comb begin
    a_we = 1'b0; a_wa = LA'(a_count); a_wd = {in_data.row, in_data.col, in_val};
    a_ra = LA'(a_idx);
    b_we = 1'b0; b_wa = cell_addr(in_data.row, in_data.col); b_wd = in_val;
    b_ra = cell_addr(r, c);
    c_we = 1'b0; c_wa = cell_addr(r, c); c_wd = '0; c_ra = cell_addr(r, c);
    case (state)
      S_SWEEP: begin
        b_we = 1'b1; b_wa = sweep; b_wd = '0;
      end
      S_IDLE: begin
        if (accept && in_data.operation == OP_LOAD_A && in_val != '0 &&
            4'(in_data.row) < a_rows && 4'(in_data.col) < a_cols &&
            32'(a_count) < MAX_NONZERO)
          a_we = 1'b1;
        if (accept && in_data.operation == OP_LOAD_B && in_val != '0 &&
            4'(in_data.row) < a_cols && 4'(in_data.col) < b_cols)
          b_we = 1'b1;
      end
      S_INIT_W: begin
        c_we = 1'b1;
        if (mul) c_wd = '0;
        else     c_wd = RES_BITS'(b_sv);
      end
      S_RMW_R: begin
        b_ra = cell_addr(ec, j);
        c_ra = cell_addr(er, mul ? j : ec);
      end
      S_RMW_W: begin
        c_we = 1'b1;
        c_wa = cell_addr(er, mul ? j : ec);
        c_wd = c_rd + prod;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (mul) prod = RES_BITS'(32'(ev) * 32'(b_sv));
    else     prod = RES_BITS'(ev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP; sweep <= '0; a_count <= '0; pend_valid <= 1'b0;
      a_rows <= DIM_BITS'(MAX_DIM); a_cols <= DIM_BITS'(MAX_DIM);
      b_cols <= DIM_BITS'(MAX_DIM);
      mul <= 1'b0; r <= '0; c <= '0; j <= '0; a_idx <= '0; stg_valid <= 1'b0;
    end else begin
      if (pend_load) pend_valid <= 1'b1;
      else if (pend_valid && out_ready) pend_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_A_ROWS: a_rows <= clamp(cfg_data);
          REG_A_COLS: a_cols <= clamp(cfg_data);
          REG_B_COLS: b_cols <= clamp(cfg_data);
          default: ;
        endcase
      end
      case (state)
        S_SWEEP: begin
          sweep <= sweep + CA'(1);
          if (32'(sweep) == CELLS - 1) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          case (in_data.operation)
            OP_LOAD_A: if (a_we) a_count <= a_count + CNT_W'(1);
            OP_CLEAR: begin
              a_count <= '0; sweep <= '0; state <= S_SWEEP;
            end
            OP_ADD, OP_MUL: begin
              mul <= (in_data.operation == OP_MUL);
              r <= '0; c <= '0; state <= S_INIT;
            end
            default: ;
          endcase
        end
        S_INIT: state <= S_INIT_W;  // B read in flight
        S_INIT_W: begin
          if (last_cell) begin
            a_idx <= '0; state <= S_AREAD;
          end else begin
            state <= S_INIT;
            if (4'(c) == ncols - 4'd1) begin c <= '0; r <= r + 3'd1; end
            else c <= c + 3'd1;
          end
        end
        S_AREAD: begin
          if (a_idx == a_count) begin
            r <= '0; c <= '0; stg_valid <= 1'b0; state <= S_SCAN;
          end else state <= S_AWAIT;
        end
        S_AWAIT: begin
          er <= a_row_rd; ec <= a_col_rd; ev <= a_val_rd; j <= '0;
          a_idx <= a_idx + CNT_W'(1);
          if (4'(a_row_rd) < a_rows && 4'(a_col_rd) < a_cols) state <= S_RMW_R;
          else state <= S_AREAD;
        end
        S_RMW_R: state <= S_RMW_W;
        S_RMW_W: begin
          if (mul && 4'(j) != b_cols - 4'd1) begin
            j <= j + 3'd1; state <= S_RMW_R;
          end else state <= S_AREAD;
        end
        S_SCAN: if (!pend_valid || out_ready) state <= S_SCAN_W;
        S_SCAN_W: begin
          // acc read done; output register known free
          if (c_rd != '0) begin
            if (stg_valid) pend <= stg;
            stg.res_row <= r; stg.res_col <= c; stg.res_value <= c_rd;
            stg.is_empty <= 1'b0; stg.last <= 1'b0;
            stg_valid <= 1'b1;
          end
          if (last_cell) state <= S_DONE;
          else begin
            state <= S_SCAN;
            if (4'(c) == ncols - 4'd1) begin c <= '0; r <= r + 3'd1; end
            else c <= c + 3'd1;
          end
        end
        S_DONE: begin
          if (!pend_valid || out_ready) begin
            if (stg_valid) begin
              pend.res_row <= stg.res_row; pend.res_col <= stg.res_col;
              pend.res_value <= stg.res_value;
              pend.is_empty <= 1'b0; pend.last <= 1'b1;
            end else begin
              pend.res_row <= '0; pend.res_col <= '0; pend.res_value <= '0;
              pend.is_empty <= 1'b1; pend.last <= 1'b1;
            end
            stg_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/tb_sparse_matrix_add_multiply.sv
// Testbench for sparse_matrix_add_multiply: directed table plus random load/compute runs.
module tb_sparse_matrix_add_multiply;
  import smam_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // DUT ports; every input driven from time zero
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DIM_BITS-1:0]     cfg_data = '0;

  sparse_matrix_add_multiply u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int DIM   = 8;
  localparam int LIST  = 64;
  localparam int DRAIN = 200;  // covers the B sweep after a clear, all 64 entries

  // Shadow copy of the block state
  logic [2:0]         a_row_q [LIST];
  logic [2:0]         a_col_q [LIST];
  logic signed [15:0] a_val_q [LIST];
  int                 a_cnt;
  logic signed [15:0] b_mat [DIM][DIM];
  int                 n_rows, n_inner, n_bcols;

  out_word_t expected_q[$];
  int        errors = 0;
  int        idle_pct = 0;   // sender gap probability, percent
  int        stall_pct = 0;  // receiver stall probability, percent

  function automatic int clamp_dim(logic [DIM_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic out_word_t mk_out(int r, int c, logic signed [RES_BITS-1:0] v,
                                       bit emp, bit lst);
    out_word_t o;
    o.res_row = r[2:0];
    o.res_col = c[2:0];
    o.res_value = v;
    o.is_empty = emp;
    o.last = lst;
    return o;
  endfunction

  // Append one expected word at the tail of the queue
  task automatic expect_word(out_word_t o);
    expected_q.insert(expected_q.size(), o);
  endtask

  // Apply one accepted word to the shadow state; queue what it produces
  task automatic predict_word(in_word_t w);
    logic signed [RES_BITS-1:0] acc [DIM][DIM];
    logic signed [RES_BITS-1:0] av, bv;
    int nr, nc, first;
    nr = n_rows;
    nc = 0;
    case (w.operation)
      OP_LOAD_A:
        if (w.value != 0 && w.row < n_rows && w.col < n_inner && a_cnt < LIST) begin
          a_row_q[a_cnt] = w.row;
          a_col_q[a_cnt] = w.col;
          a_val_q[a_cnt] = w.value;
          a_cnt++;
        end
      OP_LOAD_B:
        if (w.value != 0 && w.row < n_inner && w.col < n_bcols) b_mat[w.row][w.col] = w.value;
      OP_CLEAR: begin
        a_cnt = 0;
        foreach (b_mat[r, c]) b_mat[r][c] = '0;
      end
      OP_ADD: begin
        nc = n_inner;
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++) acc[r][c] = b_mat[r][c];
        for (int i = 0; i < a_cnt; i++)
          if (a_row_q[i] < nr && a_col_q[i] < nc) begin
            av = a_val_q[i];
            acc[a_row_q[i]][a_col_q[i]] += av;
          end
      end
      OP_MUL: begin
        nc = n_bcols;
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++) acc[r][c] = '0;
        for (int i = 0; i < a_cnt; i++)
          if (a_row_q[i] < nr && a_col_q[i] < n_inner)
            for (int j = 0; j < nc; j++) begin
              av = a_val_q[i];
              bv = b_mat[a_col_q[i]][j];
              acc[a_row_q[i]][j] += av * bv;
            end
      end
      default: ;  // undefined codes do nothing
    endcase
    if (nc != 0) begin
      first = expected_q.size();
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          if (acc[r][c] != 0) expect_word(mk_out(r, c, acc[r][c], 1'b0, 1'b0));
      if (expected_q.size() == first) expect_word(mk_out(0, 0, '0, 1'b1, 1'b1));
      else expected_q[$].last = 1'b1;
    end
  endtask

  // Sender: optional gap, then hold the word until accepted.
  // Valid stays high into the next call so it is never dropped and raised in one step.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) expect_word(typed_exp);
    else predict_word(w);
  endtask

  task automatic send(in_word_t w);
    send_word(w, 1'b0, '0);
  endtask

  // Drop valid, let every expected word arrive, then cover any tail of work
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Register writes back to back; valid lowered only after the last one
  task automatic write_dims(logic [3:0] r, logic [3:0] c, logic [3:0] b, bit junk);
    logic [CFG_IDX_BITS-1:0] idx [4];
    logic [3:0] dat [4];
    idx[0] = REG_A_ROWS; dat[0] = r;
    idx[1] = REG_A_COLS; dat[1] = c;
    idx[2] = REG_B_COLS; dat[2] = b;
    idx[3] = 2'd3;       dat[3] = 4'd5;  // unmapped index, must be ignored
    for (int i = 0; i < (junk ? 4 : 3); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    n_rows  = clamp_dim(r);
    n_inner = clamp_dim(c);
    n_bcols = clamp_dim(b);
  endtask

  function automatic in_word_t mk_in(logic [2:0] op, int r, int c, logic signed [15:0] v);
    in_word_t w;
    w.operation = op;
    w.row = r[2:0];
    w.col = c[2:0];
    w.value = v;
    return w;
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'sd0;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return 16'(signed'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_load();
    return mk_in($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B,
                 $urandom_range(7), $urandom_range(7), rand_value());
  endfunction

  // Receiver: check the accepted word, then pick next cycle's ready
  always @(posedge clk) begin
    out_word_t exp;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", out_data);
      end else begin
        exp = expected_q.pop_front();
        if (out_data !== exp) begin
          errors++;
          if (errors <= 10) $display("result mismatch: expected %p, got %p", exp, out_data);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Directed table: expected word typed only for single-result rows
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } dir_row_t;

  dir_row_t dir_tab[$];

  task automatic add_row(logic [2:0] op, int r, int c, logic signed [15:0] v);
    dir_row_t row_v;
    row_v.w = mk_in(op, r, c, v);
    row_v.typed = 1'b0;
    row_v.exp = '0;
    dir_tab.insert(dir_tab.size(), row_v);
  endtask

  task automatic add_typed(logic [2:0] op, out_word_t e);
    dir_row_t row_v;
    row_v.w = mk_in(op, 0, 0, 0);
    row_v.typed = 1'b1;
    row_v.exp = e;
    dir_tab.insert(dir_tab.size(), row_v);
  endtask

  initial begin
    int sel, nload;
    logic [3:0] dims [6][3];
    dims = '{'{4'd8, 4'd8, 4'd8}, '{4'd1, 4'd1, 4'd1}, '{4'd0, 4'd15, 4'd3},
             '{4'd15, 4'd0, 4'd8}, '{4'd3, 4'd5, 4'd2}, '{4'd6, 4'd4, 4'd7}};
    a_cnt = 0;
    foreach (b_mat[r, c]) b_mat[r][c] = '0;
    n_rows = DIM; n_inner = DIM; n_bcols = DIM;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty stores after reset, undefined codes, extremes, zero loads,
    // duplicate A coordinates, B overwrite, clear
    add_typed(OP_ADD, mk_out(0, 0, 0, 1, 1));
    add_typed(OP_MUL, mk_out(0, 0, 0, 1, 1));
    add_row(3'd5, 7, 7, 16'sh7fff);
    add_row(3'd6, 0, 0, -1);
    add_row(3'd7, 3, 3, 1);
    add_row(OP_LOAD_A, 7, 7, 16'sh8000);
    add_row(OP_LOAD_B, 7, 7, 16'sh8000);
    add_row(OP_LOAD_A, 2, 2, 16'sd0);
    add_row(OP_LOAD_B, 1, 1, 16'sd0);
    add_typed(OP_ADD, mk_out(7, 7, -40'sd65536, 0, 1));
    add_typed(OP_MUL, mk_out(7, 7, 40'sd1073741824, 0, 1));
    add_row(OP_LOAD_A, 0, 0, 16'sh7fff);
    add_row(OP_LOAD_A, 0, 0, 16'sh7fff);
    add_row(OP_LOAD_A, 0, 7, -5);
    add_row(OP_LOAD_B, 0, 3, 16'sh7fff);
    add_row(OP_LOAD_B, 0, 3, 16'sh8000);
    add_row(OP_LOAD_B, 7, 0, 9);
    add_row(OP_ADD, 0, 0, 0);
    add_row(OP_MUL, 0, 0, 0);
    add_row(OP_CLEAR, 0, 0, 0);
    add_typed(OP_ADD, mk_out(0, 0, 0, 1, 1));

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].exp);
    drain();

    // Fill the A list past its capacity at full size
    write_dims(4'd8, 4'd8, 4'd8, 1'b1);
    for (int i = 0; i < 68; i++)
      send(mk_in(OP_LOAD_A, $urandom_range(7), $urandom_range(7),
                 (i % 5 == 0) ? 16'sh8000 : 16'sh7fff));
    for (int i = 0; i < 8; i++) send(mk_in(OP_LOAD_B, i, 7 - i, 16'sh8000));
    send(mk_in(OP_ADD, 0, 0, 0));
    send(mk_in(OP_MUL, 0, 0, 0));
    send(mk_in(OP_CLEAR, 0, 0, 0));
    drain();

    // Random phases over several sizes and idle/stall mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_dims(dims[ph][0], dims[ph][1], dims[ph][2], ph == 2);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int k = 0; k < 3; k++) begin
        nload = $urandom_range(4, 1);
        for (int i = 0; i < nload; i++) send(rand_load());
        sel = $urandom_range(19);
        if (sel < 9) send(mk_in(OP_ADD, $urandom_range(7), $urandom_range(7), rand_value()));
        else if (sel < 18) send(mk_in(OP_MUL, $urandom_range(7), $urandom_range(7), rand_value()));
        else if (sel == 18) send(mk_in(OP_CLEAR, 0, 0, 0));
        else send(mk_in(3'($urandom_range(7, 5)), $urandom_range(7), $urandom_range(7), 1));
        // sender holds off until every result is back
        if (k == 1 && ph == 1) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/smam_pkg.sv
rtl/smam_ram.sv
rtl/sparse_matrix_add_multiply.sv
tb/sv/tb_sparse_matrix_add_multiply.sv
